>>> design/amu128_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amu128_pkg
// Shared types and constants of the 128-bit atomic memory unit: operation
// codes, the items of both channels, the store's write port and the ALU result.
// ----------------------------------------------------------------------------
package amu128_pkg;

  // Width of the word index carried by an input item.
  localparam int INDEX_W = 4;

  // Number of words addressable through the index field.
  localparam int INDEX_SPAN = 1 << INDEX_W;

  // Default number of stored words.
  localparam int DEPTH_DEFAULT = 16;

  // Operation codes; the fourth code performs no operation.
  localparam logic [1:0] KIND_ADD      = 2'd0;
  localparam logic [1:0] KIND_EXCHANGE = 2'd1;
  localparam logic [1:0] KIND_CAS      = 2'd2;

  // One input item.
  typedef struct packed {
    logic [1:0]         kind;
    logic [INDEX_W-1:0] index;
    logic [63:0]        operand_low;
    logic [63:0]        operand_high;
    logic [63:0]        expected_low;
    logic [63:0]        expected_high;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic        matched;
    logic [63:0] prior_low;
    logic [63:0] prior_high;
  } out_item_t;

  // Write request toward the word store.
  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] addr;
    logic [127:0]       data;
  } wr_req_t;

  // Outcome of one atomic operation on a fetched word.
  typedef struct packed {
    logic         wr;
    logic         matched;
    logic [127:0] new_word;
  } alu_res_t;

endpackage
`default_nettype wire

>>> design/amu128_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amu128_store
// Word store of the atomic memory unit: a synchronous memory with one write
// port and one registered read port, valid bits that make unwritten words
// read as zero after reset, and forwarding of a same-cycle write to the read.
// ----------------------------------------------------------------------------
module amu128_store #(
  parameter int ENTRIES = amu128_pkg::INDEX_SPAN
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            rd_en,
  input  wire logic [amu128_pkg::INDEX_W-1:0]  rd_addr,
  input  wire amu128_pkg::wr_req_t             wr,
  output logic [127:0]                         rd_data
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [amu128_pkg::INDEX_W:0] LIMIT = ENTRIES[amu128_pkg::INDEX_W:0];

  logic [127:0]       mem [ENTRIES];
  logic [ENTRIES-1:0] vld_r;
  logic [127:0]       rd_r;
  logic               rdv_r;
  logic               rd_ok;
  logic               fwd;

  // A read beyond the store, or of a word never written, returns zero.
  assign rd_ok = {1'b0, rd_addr} < LIMIT;
  assign fwd   = wr.en && (wr.addr == rd_addr);

  // Memory write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
  end

  // Registered read port; a write to the same word in this cycle is forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (fwd) begin
        rd_r <= wr.data;
      end else begin
        rd_r <= mem[rd_addr[AW-1:0]];
      end
    end
  end

  // Valid bits and the read's validity flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rdv_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr[AW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        rdv_r <= fwd || (rd_ok && vld_r[rd_addr[AW-1:0]]);
      end
    end
  end

  assign rd_data = rdv_r ? rd_r : '0;

endmodule
`default_nettype wire

>>> design/amu128_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amu128_alu
// Operation logic of the atomic memory unit: from the fetched word and the
// item's operands it forms the word to write back, the write enable and the
// compare-and-swap match flag.
// ----------------------------------------------------------------------------
module amu128_alu (
  input  wire logic [1:0]          kind,
  input  wire logic [127:0]        old_word,
  input  wire logic [127:0]        operand,
  input  wire logic [127:0]        expected,
  output amu128_pkg::alu_res_t     res
);

  logic [127:0] sum;
  logic         equal;

  // Full 128-bit sum, wrapping modulo 2^128.
  assign sum   = old_word + operand;
  assign equal = (old_word == expected);

  // Select the write-back value per operation.
  always_comb begin
    res = '0;
    case (kind)
      amu128_pkg::KIND_ADD: begin
        res.wr       = 1'b1;
        res.new_word = sum;
      end
      amu128_pkg::KIND_EXCHANGE: begin
        res.wr       = 1'b1;
        res.new_word = operand;
      end
      amu128_pkg::KIND_CAS: begin
        res.wr       = equal;
        res.matched  = equal;
        res.new_word = operand;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> design/atomic_memory_unit_128_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atomic_memory_unit_128_core
// Atomic memory unit over a small store of 128-bit words: add, exchange and
// compare-and-swap, each returning the word's prior contents.
// ----------------------------------------------------------------------------
// Usage:
//   An item on the in_ channel names an operation and a word. It is taken at
//   a clock edge where in_valid is high and in_stall is low. Exactly one
//   result item follows on the out_ channel, in order.
//   Order: the word is read from the store into its read register as the
//   item is taken into the execute stage; there the operation is applied,
//   and as the item retires the word is written back and the result is
//   loaded into the output register, which shows it on the out_ channel.
//   Throughput: one item per cycle while out_stall is low. A write and a
//   read of the same word in one cycle are forwarded, so back-to-back items
//   on one word need no gap.
//   Reset: all words read as zero after reset; valid bits per word are
//   cleared at once, so there is no clearing pass and items are taken from
//   the first cycle after reset.
//   Stall: while out_stall holds a waiting result, one more item may be
//   taken and held with its fetched word; after that in_stall rises.
// ----------------------------------------------------------------------------
module atomic_memory_unit_128_core #(
  parameter int DEPTH = amu128_pkg::DEPTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire amu128_pkg::in_item_t  in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output amu128_pkg::out_item_t      out_item
);

  // Only the words reachable through the index field are kept.
  localparam int ENTRIES = (DEPTH < amu128_pkg::INDEX_SPAN) ? DEPTH : amu128_pkg::INDEX_SPAN;
  localparam logic [amu128_pkg::INDEX_W:0] LIMIT = ENTRIES[amu128_pkg::INDEX_W:0];

  logic                   s1_v_r;
  logic                   s1_inr_r;
  amu128_pkg::in_item_t   s1_item_r;
  logic                   out_valid_r;
  amu128_pkg::out_item_t  out_item_r;
  amu128_pkg::out_item_t  result;
  amu128_pkg::wr_req_t    wr;
  amu128_pkg::alu_res_t   alu;
  logic [127:0]           old_word;
  logic                   in_acc;
  logic                   advance;
  logic                   in_range;

  // Handshake: the execute stage retires when the output register is free.
  assign advance  = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_v_r && !advance;
  assign in_acc   = in_valid && !in_stall;
  assign in_range = {1'b0, in_item.index} < LIMIT;

  // Word store with read at accept and write-back at retire.
  amu128_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (in_item.index),
    .wr      (wr),
    .rd_data (old_word)
  );

  // Operation applied to the fetched word.
  amu128_alu u_alu (
    .kind     (s1_item_r.kind),
    .old_word (old_word),
    .operand  ({s1_item_r.operand_high, s1_item_r.operand_low}),
    .expected ({s1_item_r.expected_high, s1_item_r.expected_low}),
    .res      (alu)
  );

  // Write-back, suppressed for an index beyond the store.
  always_comb begin
    wr.en   = advance && s1_inr_r && alu.wr;
    wr.addr = s1_item_r.index;
    wr.data = alu.new_word;
  end

  // Result formed from the word before the operation.
  always_comb begin
    result = '0;
    if (s1_inr_r) begin
      result.matched    = alu.matched;
      result.prior_low  = old_word[63:0];
      result.prior_high = old_word[127:64];
    end
  end

  // Execute stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (advance) begin
      s1_v_r <= 1'b0;
    end
  end

  // Execute stage payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
      s1_inr_r  <= in_range;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A match is only reported by compare-and-swap, and always writes back.
  a_match_cas : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && result.matched) |-> (s1_item_r.kind == amu128_pkg::KIND_CAS && wr.en))
    else $error("match reported without a compare-and-swap write");

  // A held item keeps its payload while the output side is blocked.
  a_hold_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !advance) |=> (s1_v_r && $stable(s1_item_r)))
    else $error("execute stage lost or changed a held item");

  // An accepted item reaches the execute stage on the next cycle.
  a_acc_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r)
    else $error("accepted item did not enter the execute stage");

  // A retiring item always leaves a visible result.
  a_retire_out : assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("retired item produced no result");

endmodule
`default_nettype wire

>>> bench/tb_atomic_memory_unit_128_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_atomic_memory_unit_128_core
// Self-checking bench for the 128-bit atomic memory unit. A short table of
// directed items covers the edges of add, exchange and compare-and-swap, then
// random items follow in phases. Both channels idle at random. Every result is
// compared against a typed row's result or the bench's shadow word store.
// ----------------------------------------------------------------------------
module tb_atomic_memory_unit_128_core;

  localparam int          DEPTH        = amu128_pkg::DEPTH_DEFAULT;
  localparam logic [1:0]  KIND_NONE    = 2'd3;
  localparam logic [63:0] ONES         = {64{1'b1}};
  localparam int          RANDOM_ITEMS = 1150;
  localparam int          PHASE_ITEMS  = 115;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          DRAIN_CYCLES = 8;

  // One row of the directed table; result is used only when typed is set.
  typedef struct packed {
    amu128_pkg::in_item_t  item;
    logic                  typed;
    amu128_pkg::out_item_t result;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  amu128_pkg::in_item_t  in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  amu128_pkg::out_item_t out_item;

  logic [127:0]          word_image [DEPTH];
  amu128_pkg::out_item_t awaited_results [$];
  plan_row_t             directed_plan [$];
  int                    errors   = 0;
  int                    idle_run = 0;
  bit                    quiet    = 1'b0;

  atomic_memory_unit_128_core #(.DEPTH(DEPTH)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one item to the shadow store and returns the result it should give.
  function automatic amu128_pkg::out_item_t atomic_outcome(amu128_pkg::in_item_t it);
    amu128_pkg::out_item_t r;
    logic [127:0]          old_w;
    logic [127:0]          opnd;
    r = '0;
    opnd = {it.operand_high, it.operand_low};
    if (it.index < DEPTH) begin
      old_w = word_image[it.index];
      r.prior_low  = old_w[63:0];
      r.prior_high = old_w[127:64];
      case (it.kind)
        amu128_pkg::KIND_ADD: begin
          word_image[it.index] = old_w + opnd;
        end
        amu128_pkg::KIND_EXCHANGE: begin
          word_image[it.index] = opnd;
        end
        amu128_pkg::KIND_CAS: begin
          if (old_w == {it.expected_high, it.expected_low}) begin
            word_image[it.index] = opnd;
            r.matched = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  function automatic amu128_pkg::in_item_t make_item(logic [1:0] op, int idx,
                                                     logic [63:0] op_lo,
                                                     logic [63:0] op_hi,
                                                     logic [63:0] ex_lo,
                                                     logic [63:0] ex_hi);
    amu128_pkg::in_item_t it;
    it.kind          = op;
    it.index         = idx[amu128_pkg::INDEX_W-1:0];
    it.operand_low   = op_lo;
    it.operand_high  = op_hi;
    it.expected_low  = ex_lo;
    it.expected_high = ex_hi;
    return it;
  endfunction

  task automatic plan(amu128_pkg::in_item_t it, logic typed, logic m, logic [63:0] p_lo,
                      logic [63:0] p_hi);
    plan_row_t row;
    row.item              = it;
    row.typed             = typed;
    row.result.matched    = m;
    row.result.prior_low  = p_lo;
    row.result.prior_high = p_hi;
    directed_plan.push_back(row);
  endtask

  // Wait drawn by either side before its next item; none in quiet phases.
  function automatic int idle_draw();
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  // Biased 64-bit half: zero, all ones, near either end, or fully random.
  function automatic logic [63:0] pick_half();
    logic [63:0] v;
    v = 64'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ONES;
      2: return v;
      3: return ONES - v;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Random item drawn against the current shadow store, so that
  // compare-and-swap hits often and adds reach the carry boundaries.
  function automatic amu128_pkg::in_item_t random_item(int lo_idx, int hi_idx);
    amu128_pkg::in_item_t it;
    logic [127:0]         cur;
    logic [127:0]         near;
    int                   pick;
    int                   idx;
    idx = $urandom_range(hi_idx, lo_idx);
    it.index = idx[amu128_pkg::INDEX_W-1:0];
    pick = $urandom_range(0, 15);
    if (pick < 5) begin
      it.kind = amu128_pkg::KIND_ADD;
    end else if (pick < 9) begin
      it.kind = amu128_pkg::KIND_EXCHANGE;
    end else if (pick < 15) begin
      it.kind = amu128_pkg::KIND_CAS;
    end else begin
      it.kind = KIND_NONE;
    end
    it.operand_low   = pick_half();
    it.operand_high  = pick_half();
    it.expected_low  = pick_half();
    it.expected_high = pick_half();
    cur = word_image[it.index];
    case ($urandom_range(0, 3))
      0, 1: begin
        {it.expected_high, it.expected_low} = cur;
      end
      2: begin
        near = cur;
        near[$urandom_range(0, 127)] ^= 1'b1;
        {it.expected_high, it.expected_low} = near;
      end
      default: begin
      end
    endcase
    // Make the low half wrap to zero, and sometimes the high half as well.
    if (it.kind == amu128_pkg::KIND_ADD && $urandom_range(0, 3) == 0) begin
      it.operand_low = ~cur[63:0] + 64'd1;
      if ($urandom_range(0, 1)) begin
        it.operand_high = ~cur[127:64];
      end
    end
    return it;
  endfunction

  // Offers one item after a random gap and records its expected result.
  task automatic send_item(amu128_pkg::in_item_t it, logic typed,
                           amu128_pkg::out_item_t typed_res);
    amu128_pkg::out_item_t predicted;
    repeat (idle_draw()) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = atomic_outcome(it);
    awaited_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
    errors++;
  endtask

  // Stimulus: reset, the directed table, then random phases.
  initial begin
    int lo;
    int hi;
    for (int w = 0; w < DEPTH; w++) begin
      word_image[w] = '0;
    end

    // Directed table; typed rows carry a result readable at a glance.
    plan(make_item(amu128_pkg::KIND_CAS, 0, ONES, ONES, 64'd0, 64'd0),
         1'b1, 1'b1, 64'd0, 64'd0);
    plan(make_item(amu128_pkg::KIND_ADD, 0, 64'd1, 64'd0, 64'd0, 64'd0),
         1'b1, 1'b0, ONES, ONES);
    plan(make_item(KIND_NONE, 0, ONES, ONES, ONES, ONES), 1'b1, 1'b0, 64'd0, 64'd0);
    plan(make_item(amu128_pkg::KIND_EXCHANGE, 15, 64'h0123_4567_89ab_cdef,
                   64'hfedc_ba98_7654_3210, ONES, ONES), 1'b1, 1'b0, 64'd0, 64'd0);
    plan(make_item(KIND_NONE, 15, ONES, ONES, 64'd0, 64'd0), 1'b0, 1'b0, '0, '0);
    // Compare value right in one half only: no swap; then right in both: swap.
    plan(make_item(amu128_pkg::KIND_CAS, 15, ONES, ONES, 64'h0123_4567_89ab_cdef, 64'd0),
         1'b0, 1'b0, '0, '0);
    plan(make_item(amu128_pkg::KIND_CAS, 15, ONES, ONES, 64'd0, 64'hfedc_ba98_7654_3210),
         1'b0, 1'b0, '0, '0);
    plan(make_item(amu128_pkg::KIND_CAS, 15, ONES, 64'd0, 64'h0123_4567_89ab_cdef,
                   64'hfedc_ba98_7654_3210), 1'b0, 1'b0, '0, '0);
    // Carry from the low half into the high half.
    plan(make_item(amu128_pkg::KIND_EXCHANGE, 3, ONES, 64'd0, 64'd0, 64'd0),
         1'b1, 1'b0, 64'd0, 64'd0);
    plan(make_item(amu128_pkg::KIND_ADD, 3, 64'd1, 64'd0, 64'd0, 64'd0),
         1'b0, 1'b0, '0, '0);
    plan(make_item(KIND_NONE, 3, 64'd0, 64'd0, 64'd0, 64'd0), 1'b0, 1'b0, '0, '0);
    // The carry alone makes the high half wrap to zero.
    plan(make_item(amu128_pkg::KIND_EXCHANGE, 4, ONES, 64'd0, 64'd0, 64'd0),
         1'b1, 1'b0, 64'd0, 64'd0);
    plan(make_item(amu128_pkg::KIND_ADD, 4, 64'd1, ONES, 64'd0, 64'd0),
         1'b0, 1'b0, '0, '0);
    plan(make_item(KIND_NONE, 4, 64'd0, 64'd0, 64'd0, 64'd0), 1'b0, 1'b0, '0, '0);
    // Full-scale add twice, so the sum wraps past 2^128.
    plan(make_item(amu128_pkg::KIND_ADD, 5, ONES, ONES, 64'd0, 64'd0),
         1'b1, 1'b0, 64'd0, 64'd0);
    plan(make_item(amu128_pkg::KIND_ADD, 5, ONES, ONES, 64'd0, 64'd0),
         1'b0, 1'b0, '0, '0);
    plan(make_item(amu128_pkg::KIND_EXCHANGE, 5, 64'd0, 64'd0, 64'd0, 64'd0),
         1'b0, 1'b0, '0, '0);
    plan(make_item(amu128_pkg::KIND_CAS, 7, 64'd0, 64'd0, 64'd0, 64'd0),
         1'b1, 1'b1, 64'd0, 64'd0);
    plan(make_item(amu128_pkg::KIND_CAS, 7, ONES, ONES, ONES, ONES),
         1'b1, 1'b0, 64'd0, 64'd0);
    plan(make_item(amu128_pkg::KIND_ADD, 15, 64'd0, 64'd0, ONES, ONES),
         1'b0, 1'b0, '0, '0);
    // Consecutive items on one word exercise forwarding when no gap is drawn.
    plan(make_item(amu128_pkg::KIND_EXCHANGE, 8, 64'h8000_0000_0000_0001,
                   64'h7fff_ffff_ffff_fffe, 64'd0, 64'd0), 1'b0, 1'b0, '0, '0);
    plan(make_item(amu128_pkg::KIND_ADD, 8, ONES, 64'd1, 64'd0, 64'd0),
         1'b0, 1'b0, '0, '0);
    plan(make_item(amu128_pkg::KIND_CAS, 8, 64'h5555_5555_5555_5555,
                   64'haaaa_aaaa_aaaa_aaaa, 64'h8000_0000_0000_0000,
                   64'h8000_0000_0000_0000), 1'b0, 1'b0, '0, '0);
    plan(make_item(KIND_NONE, 8, ONES, ONES, ONES, ONES), 1'b0, 1'b0, '0, '0);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      send_item(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].result);
    end

    // Random phases, some without idling, some focused on a pair of words.
    for (int p = 0; p < RANDOM_ITEMS / PHASE_ITEMS; p++) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) begin
        lo = $urandom_range(0, DEPTH - 2);
        hi = lo + 1;
      end else begin
        lo = 0;
        hi = DEPTH - 1;
      end
      repeat (PHASE_ITEMS) send_item(random_item(lo, hi), 1'b0, '0);
    end
    quiet = 1'b0;

    // Drain, then give stray results a chance to show up.
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_atomic_memory_unit_128_core: PASS");
    end else begin
      $display("tb_atomic_memory_unit_128_core: FAIL");
    end
    $finish;
  end

  // Result side: stall for a drawn number of cycles, then take one item.
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      hold = idle_draw();
      if (hold > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    amu128_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report("result with none pending, prior_low", '0, out_item.prior_low);
      end else begin
        want = awaited_results.pop_front();
        if (out_item.matched !== want.matched) begin
          report("matched", {63'd0, want.matched}, {63'd0, out_item.matched});
        end
        if (out_item.prior_low !== want.prior_low) begin
          report("prior_low", want.prior_low, out_item.prior_low);
        end
        if (out_item.prior_high !== want.prior_high) begin
          report("prior_high", want.prior_high, out_item.prior_high);
        end
      end
    end
  end

  // Watchdog: too long without any item moving on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run == STALL_LIMIT) begin
        $display("tb_atomic_memory_unit_128_core: FAIL");
        $finish;
      end
    end
  end

endmodule
`default_nettype wire
